// ===== rtl/mrrp_pkg.sv =====
`default_nettype none

package mrrp_pkg;

   localparam int AMOUNT_W    = 20;
   localparam int READER_W    = 3;
   localparam int OFFSET_W    = 19;
   localparam int CFG_W       = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd1;

   // classified request, as queued between front and back
   typedef struct packed {
      logic                mode;
      logic [AMOUNT_W-1:0] amount;
      logic [READER_W-1:0] reader;
      logic                stored;   // reader has a pointer slot
      logic                pop_ok;   // pop of an active reader
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [OFFSET_W-1:0] write_offset;
      logic [OFFSET_W-1:0] read_offset;
      logic [OFFSET_W-1:0] readable;
      logic [OFFSET_W-1:0] writable;
      logic [OFFSET_W-1:0] space_free;
      logic [OFFSET_W-1:0] space_used;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE,
      ST_REPORT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mrrp_front.sv =====
`default_nettype none

module mrrp_front #(
   parameter int MAX_READERS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 mode,
   input  logic [mrrp_pkg::AMOUNT_W-1:0]        amount,
   input  logic [mrrp_pkg::READER_W-1:0]        reader,
   input  logic [$clog2(MAX_READERS+1)-1:0]     n_active,
   output logic                                 q_empty,
   output mrrp_pkg::req_type                    q_head,
   input  logic                                 q_pop
);
   import mrrp_pkg::*;

   localparam int NW  = $clog2(MAX_READERS + 1);
   localparam int XW  = READER_W + NW;
   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   req_type        q_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ff, wr_in;
   logic [QPW-1:0] rd_ff, rd_in;
   logic [QCW-1:0] cnt_ff, cnt_in;

   req_type        cls;
   logic [XW-1:0]  reader_x;
   logic [XW-1:0]  active_x;
   logic           do_wr;
   logic           do_rd;

   // classification
   always_comb begin
      reader_x   = {{NW{1'b0}}, reader};
      active_x   = {{READER_W{1'b0}}, n_active};
      cls.mode   = mode;
      cls.amount = amount;
      cls.reader = reader;
      cls.stored = reader_x < XW'(MAX_READERS);
      cls.pop_ok = (mode == MODE_POP) && cls.stored && (reader_x < active_x);
   end

   assign full    = cnt_ff == QCW'(QUEUE_DEPTH);
   assign q_empty = cnt_ff == '0;
   assign q_head  = q_ff[rd_ff];
   assign do_wr   = push && !full;
   assign do_rd   = q_pop && !q_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wr_in = (wr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPW'(1);
      end
      if (do_rd) begin
         rd_in = (rd_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mrrp_back.sv =====
`default_nettype none

module mrrp_back #(
   parameter int BUF_SIZE    = 524288,
   parameter int MAX_READERS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_READERS+1)-1:0] n_active,
   input  logic                             q_empty,
   input  mrrp_pkg::req_type                q_head,
   output logic                             q_pop,
   output logic                             rsp_valid,
   output mrrp_pkg::rsp_type                rsp,
   input  logic                             rsp_pop
);
   import mrrp_pkg::*;

   localparam int PW = $clog2(BUF_SIZE);
   localparam int NW = $clog2(MAX_READERS + 1);
   localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int CW = ((PW > AMOUNT_W) ? PW : AMOUNT_W) + 1;
   localparam int XW = READER_W + RW;
   localparam logic [CW-1:0] SIZE = CW'(BUF_SIZE);
   localparam logic [CW-1:0] ONE  = CW'(1);

   // read pointer store: one write port, two registered read ports
   logic [PW-1:0]          rp_mem [MAX_READERS];
   logic [MAX_READERS-1:0] rp_vld_ff;
   logic [RW-1:0]          addr_a;
   logic [RW-1:0]          addr_b;
   logic [PW-1:0]          rdata_a_ff;
   logic [PW-1:0]          rdata_b_ff;
   logic                   we;
   logic [PW-1:0]          wdata;
   logic [XW-1:0]          reader_x;

   state_type     state_ff, state_in;
   logic          phase_ff, phase_in;      // 0 before update, 1 after
   req_type       cur_ff, cur_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] best_ff, best_in;
   logic          have_ff, have_in;
   logic          scan_vld_ff, scan_vld_in;
   logic          acc_ff, acc_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_vld_ff, rsp_vld_in;

   logic [CW-1:0] wp_x, t_x, p_x, a_x, amt_x;
   logic          t_ahead, p_ahead, a_ahead, take;
   logic [CW-1:0] writable, readable, space_free, space_used;
   logic [CW-1:0] wp_sum, wp_next, p_sum, p_next;
   logic          push_fit, pop_fit;

   assign reader_x = {{RW{1'b0}}, cur_ff.reader};
   assign addr_b   = cur_ff.stored ? reader_x[RW-1:0] : '0;
   assign addr_a   = (state_ff == ST_SCAN) ? cnt_ff[RW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (we) begin
         rp_mem[addr_b] <= wdata;
      end
      rdata_a_ff <= rp_vld_ff[addr_a] ? rp_mem[addr_a] : '0;
      rdata_b_ff <= rp_vld_ff[addr_b] ? rp_mem[addr_b] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_vld_ff <= '0;
      end else if (we) begin
         rp_vld_ff[addr_b] <= 1'b1;
      end
   end

   // pointer arithmetic
   always_comb begin
      wp_x    = CW'(wp_ff);
      t_x     = CW'(best_ff);
      p_x     = CW'(rdata_b_ff);
      a_x     = CW'(rdata_a_ff);
      amt_x   = CW'(cur_ff.amount);
      t_ahead = wp_x < t_x;
      p_ahead = wp_x < p_x;
      a_ahead = wp_x < a_x;

      if (t_ahead) begin
         writable = t_x - wp_x - ONE;
      end else if (t_x != '0) begin
         writable = SIZE - wp_x;
      end else begin
         writable = SIZE - wp_x - ONE;
      end
      readable   = p_ahead ? SIZE - p_x : wp_x - p_x;
      space_free = t_ahead ? t_x - wp_x - ONE : SIZE - wp_x + t_x - ONE;
      space_used = t_ahead ? SIZE - t_x + wp_x : wp_x - t_x;

      wp_sum   = wp_x + amt_x;
      wp_next  = (wp_sum >= SIZE) ? wp_sum - SIZE : wp_sum;
      p_sum    = p_x + amt_x;
      p_next   = (p_sum >= SIZE) ? p_sum - SIZE : p_sum;
      push_fit = amt_x <= writable;
      pop_fit  = cur_ff.pop_ok && (amt_x <= readable);

      // wrapped readers rank first, then lowest pointer
      take = scan_vld_ff && (!have_ff || ({!a_ahead, rdata_a_ff} < {!t_ahead, best_ff}));
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cur_in      = cur_ff;
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      best_in     = best_ff;
      have_in     = have_ff;
      acc_in      = acc_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_pop;
      scan_vld_in = 1'b0;
      q_pop       = 1'b0;
      we          = 1'b0;
      wdata       = p_next[PW-1:0];

      if (take) begin
         best_in = rdata_a_ff;
         have_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               cnt_in   = '0;
               have_in  = 1'b0;
               phase_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_vld_in = 1'b1;
            cnt_in      = cnt_ff + NW'(1);
            if ((cnt_ff + NW'(1)) == n_active) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = phase_ff ? ST_REPORT : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cur_ff.mode == MODE_PUSH) begin
               acc_in = push_fit;
               if (push_fit) begin
                  wp_in = wp_next[PW-1:0];
               end
            end else begin
               acc_in = pop_fit;
               we     = pop_fit;
            end
            phase_in = 1'b1;
            cnt_in   = '0;
            have_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_REPORT: begin
            if (!rsp_vld_ff || rsp_pop) begin
               rsp_in.accepted     = acc_ff;
               rsp_in.write_offset = wp_x[OFFSET_W-1:0];
               rsp_in.read_offset  = cur_ff.stored ? p_x[OFFSET_W-1:0] : '0;
               rsp_in.readable     = cur_ff.stored ? readable[OFFSET_W-1:0] : '0;
               rsp_in.writable     = writable[OFFSET_W-1:0];
               rsp_in.space_free   = space_free[OFFSET_W-1:0];
               rsp_in.space_used   = space_used[OFFSET_W-1:0];
               rsp_vld_in          = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= 1'b0;
         wp_ff       <= '0;
         scan_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         wp_ff       <= wp_in;
         scan_vld_ff <= scan_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      best_ff <= best_in;
      have_ff <= have_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/multi_reader_ring_pointers.sv =====
// Pointer manager for a ring buffer with one writer and several readers.
// Request channel (req_push / req_full): mode 0 advances the write pointer,
// mode 1 advances the read pointer of req_reader, each by req_amount.
// A request that does not fit its contiguous span, or a pop of an
// inactive reader, is refused and moves nothing. Every request yields one
// response on the rsp_ side (rsp_empty / rsp_pop): accept flag, both
// pointers, both spans, free and used space. csr_we / csr_wdata set the
// number of active readers; write only while no request is in flight.
// The back end handles one request at a time: IDLE, SCAN, LAST, DECIDE,
// then SCAN and LAST again and REPORT. The slowest-reader search walks the
// read pointer memory one reader per cycle over the N active readers (after
// saturation), once before the update and once after it.
// Reset: all pointers zero, one active reader, queue and response empty.
// A stalled response holds its register; the back end waits on it and the
// two-entry request queue fills, then req_full rises.
`default_nettype none

module multi_reader_ring_pointers #(
   parameter int BUF_SIZE    = 524288,
   parameter int MAX_READERS = 8
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_mode,
   input  logic [mrrp_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic [mrrp_pkg::READER_W-1:0]  req_reader,

   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_accepted,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_write_offset,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_read_offset,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_readable,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_writable,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_space_free,
   output logic [mrrp_pkg::OFFSET_W-1:0]  rsp_space_used,

   input  logic                           csr_we,
   input  logic [mrrp_pkg::CFG_W-1:0]     csr_wdata
);
   import mrrp_pkg::*;

   localparam int NW = $clog2(MAX_READERS + 1);
   localparam int AW = NW + CFG_W;

   logic [CFG_W-1:0] active_readers_ff;
   logic [AW-1:0]    active_x;
   logic [AW-1:0]    active_sat;
   logic [NW-1:0]    n_active;

   req_type q_head;
   logic    q_empty;
   logic    q_pop;
   rsp_type rsp;
   logic    rsp_valid;

   // active reader register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_readers_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         active_readers_ff <= csr_wdata;
      end
   end

   // zero counts as one, above the storage saturates
   always_comb begin
      active_x = {{NW{1'b0}}, active_readers_ff};
      if (active_x == '0) begin
         active_sat = AW'(1);
      end else if (active_x > AW'(MAX_READERS)) begin
         active_sat = AW'(MAX_READERS);
      end else begin
         active_sat = active_x;
      end
      n_active = active_sat[NW-1:0];
   end

   // front: accepts and classifies requests into a short queue
   mrrp_front #(
      .MAX_READERS (MAX_READERS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .mode     (req_mode),
      .amount   (req_amount),
      .reader   (req_reader),
      .n_active (n_active),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // back: slowest-reader search, pointer update, response register
   mrrp_back #(
      .BUF_SIZE    (BUF_SIZE),
      .MAX_READERS (MAX_READERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .n_active  (n_active),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty        = !rsp_valid;
   assign rsp_accepted     = rsp.accepted;
   assign rsp_write_offset = rsp.write_offset;
   assign rsp_read_offset  = rsp.read_offset;
   assign rsp_readable     = rsp.readable;
   assign rsp_writable     = rsp.writable;
   assign rsp_space_free   = rsp.space_free;
   assign rsp_space_used   = rsp.space_used;

endmodule

`default_nettype wire
